// ----- rtl/core/pkbfi_pkg.sv -----
// Shared types and constants for the packed key bucket find-or-insert block.
// No dependencies.
`timescale 1ns / 1ps
package pkbfi_pkg;
    localparam int BUCKET_BYTES = 4096;
    localparam int MAX_KEY_LEN  = 64;
    localparam int VAL_BYTES    = 4;
    localparam int HDR_BYTES    = 2;
    localparam int AW           = $clog2(BUCKET_BYTES);
    localparam int UW           = AW + 1;
    localparam int KW           = $clog2(MAX_KEY_LEN);
    localparam int KLW          = KW + 1;
    localparam int QDEPTH       = 2;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    // Completed key job handed from front to back.
    typedef struct packed {
        logic             overflow;
        logic [KLW-1:0]   len;
        logic [31:0]      value;
        logic             bank;
    } t_job;

    typedef enum logic [3:0] {
        BS_IDLE, BS_HDR0, BS_HDR1, BS_CHK, BS_CMP, BS_VAL, BS_INS_HDR0, BS_INS_HDR1,
        BS_INS_KEY, BS_INS_VAL, BS_DONE
    } t_bstate;
endpackage

// ----- rtl/core/pkbfi_if.sv -----
// Valid/ready stream interface used by both channels.
// Depends on nothing.
`timescale 1ns / 1ps
interface pkbfi_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] new_value;
    modport source (output valid, key_byte, key_last, new_value, input ready);
    modport sink (input valid, key_byte, key_last, new_value, output ready);
endinterface

interface pkbfi_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] entry_offset;
    logic [31:0] stored_value;
    modport source (output valid, status, entry_offset, stored_value, input ready);
    modport sink (input valid, status, entry_offset, stored_value, output ready);
endinterface

// ----- rtl/core/packed_key_bucket_find_or_insert.sv -----
// Top level of the packed key bucket find-or-insert block.
// Depends on pkbfi_pkg, pkbfi_if, pkbfi_front and pkbfi_back.
`timescale 1ns / 1ps
// Key bytes are taken one per cycle into a two-bank key buffer, so the next
// key can stream in while the previous one is looked up; the input stalls
// only while both banks hold keys whose result has not been produced yet.
// Each completed key then walks the 4096-byte bucket memory entry by entry
// through its single read port: it reads each entry header, compares the
// key bytes, and on a hit fetches the value and reports. An insert writes
// the two header bytes, then the key bytes, then the four value bytes. No
// clearing pass is needed after reset.
module packed_key_bucket_find_or_insert (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pkbfi_in_if.sink      s_in,
    pkbfi_out_if.source   m_out
);
    logic                          w_job_valid, w_job_ready, w_rd_bank, w_job_done;
    pkbfi_pkg::t_job               w_job;
    logic [pkbfi_pkg::KW-1:0]      w_rd_idx;
    logic [7:0]                    w_rd_data;

    pkbfi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_key_byte(s_in.key_byte), .i_key_last(s_in.key_last),
        .i_new_value(s_in.new_value),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job),
        .i_job_done(w_job_done),
        .i_rd_bank(w_rd_bank), .i_rd_idx(w_rd_idx), .o_rd_data(w_rd_data)
    );

    pkbfi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_job_done(w_job_done),
        .o_rd_bank(w_rd_bank), .o_rd_idx(w_rd_idx), .i_rd_data(w_rd_data),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_status(m_out.status), .o_entry_offset(m_out.entry_offset),
        .o_stored_value(m_out.stored_value)
    );
endmodule

// ----- rtl/core/pkbfi_front.sv -----
// Front end: collects key bytes into a two-bank key buffer and emits jobs.
// Depends on pkbfi_pkg.
`timescale 1ns / 1ps
module pkbfi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_key_byte,
    input  logic                         i_key_last,
    input  logic [31:0]                  i_new_value,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output pkbfi_pkg::t_job              o_job,
    input  logic                         i_job_done,
    input  logic                         i_rd_bank,
    input  logic [pkbfi_pkg::KW-1:0]     i_rd_idx,
    output logic [7:0]                   o_rd_data
);
    logic [7:0]                  r_kbuf [2*pkbfi_pkg::MAX_KEY_LEN];
    logic [pkbfi_pkg::KLW-1:0]   r_len, n_len;
    logic                        r_ovf, n_ovf;
    logic                        r_bank;
    // banks owned by jobs that have not been answered yet
    logic [1:0]                  r_bcnt;
    // jobs waiting in the queue
    logic [1:0]                  r_qcnt;
    pkbfi_pkg::t_job             r_q [pkbfi_pkg::QDEPTH];
    logic                        r_wp, r_rp;
    logic                        w_acc, w_push, w_pop;

    assign o_ready = (r_bcnt != 2'd2);
    assign w_acc   = i_valid && o_ready;
    assign w_push  = w_acc && i_key_last;
    assign w_pop   = o_job_valid && i_job_ready;
    assign o_job_valid = (r_qcnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_acc) begin
            if (r_len < pkbfi_pkg::KLW'(pkbfi_pkg::MAX_KEY_LEN)) n_len = r_len + 1'b1;
            else n_ovf = 1'b1;
            if (i_key_last) begin
                n_len = '0;
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_ovf <= 1'b0; r_bank <= 1'b0;
            r_bcnt <= '0; r_qcnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (w_push) begin
                r_bank <= ~r_bank;
                r_wp   <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_qcnt <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
            // a bank is free again once the back end has answered its job
            r_bcnt <= r_bcnt + {1'b0, w_push} - {1'b0, i_job_done};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_len < pkbfi_pkg::KLW'(pkbfi_pkg::MAX_KEY_LEN))
            r_kbuf[{r_bank, r_len[pkbfi_pkg::KW-1:0]}] <= i_key_byte;
        if (w_push) begin
            r_q[r_wp].overflow <= r_ovf || (r_len == pkbfi_pkg::KLW'(pkbfi_pkg::MAX_KEY_LEN));
            r_q[r_wp].len      <= (r_len == pkbfi_pkg::KLW'(pkbfi_pkg::MAX_KEY_LEN))
                                  ? r_len : r_len + 1'b1;
            r_q[r_wp].value    <= i_new_value;
            r_q[r_wp].bank     <= r_bank;
        end
        o_rd_data <= r_kbuf[{i_rd_bank, i_rd_idx}];
    end

`ifndef NO_ASSERTIONS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_bcnt <= 2'd2)
        else $error("bank count overflow");
    a_nopush_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt == 2'd2 |-> !w_push) else $error("push with both banks busy");
    a_len_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_len == '0) else $error("key length not cleared");
`endif
endmodule

// ----- rtl/core/pkbfi_back.sv -----
// Back end: scans the bucket memory, compares, appends and reports.
// Depends on pkbfi_pkg.
`timescale 1ns / 1ps
module pkbfi_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  pkbfi_pkg::t_job              i_job,
    output logic                         o_job_done,
    output logic                         o_rd_bank,
    output logic [pkbfi_pkg::KW-1:0]     o_rd_idx,
    input  logic [7:0]                   i_rd_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [11:0]                  o_entry_offset,
    output logic [31:0]                  o_stored_value
);
    localparam int AW = pkbfi_pkg::AW;
    localparam int UW = pkbfi_pkg::UW;
    localparam int KLW = pkbfi_pkg::KLW;

    logic [7:0]            r_mem [pkbfi_pkg::BUCKET_BYTES];
    logic [7:0]            r_rdata;
    pkbfi_pkg::t_bstate    r_st, n_st;
    logic [UW-1:0]         r_used, r_pos, r_idx, r_elen;
    logic [KLW-1:0]        r_kidx;
    logic [31:0]           r_val;
    logic [1:0]            r_vb;
    logic                  r_pend;
    logic                  r_done;
    logic                  r_ovalid;
    logic [1:0]            r_ostat;
    logic [11:0]           r_ooff;
    logic [31:0]           r_oval;
    pkbfi_pkg::t_job       r_job;
    logic [UW-1:0]         w_raddr;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [7:0]            w_wdata;
    logic [UW+1:0]         w_end, w_need;
    logic                  w_mis, w_klast, w_full;

    assign o_valid = r_ovalid;
    assign o_status = r_ostat;
    assign o_entry_offset = r_ooff;
    assign o_stored_value = r_oval;
    assign o_job_done = r_done;
    assign o_job_ready = (r_st == pkbfi_pkg::BS_IDLE) && !r_ovalid;
    assign o_rd_bank = r_job.bank;
    assign o_rd_idx  = r_kidx[pkbfi_pkg::KW-1:0];
    assign w_end  = {2'b0, r_pos} + (UW+2)'(pkbfi_pkg::HDR_BYTES + pkbfi_pkg::VAL_BYTES)
                    + {2'b0, r_elen};
    assign w_need = {2'b0, r_used} + (UW+2)'(pkbfi_pkg::HDR_BYTES + pkbfi_pkg::VAL_BYTES)
                    + (UW+2)'(r_job.len);
    assign w_mis   = (r_rdata != i_rd_data);
    assign w_klast = (r_kidx + 1'b1 == r_job.len);
    assign w_full  = (w_need > (UW+2)'(pkbfi_pkg::BUCKET_BYTES));

    // memory address: scan cursor r_idx
    assign w_raddr = r_idx;

    always_comb begin
        n_st = r_st;
        case (r_st)
            pkbfi_pkg::BS_IDLE: if (i_job_valid && o_job_ready && !i_job.overflow)
                n_st = pkbfi_pkg::BS_CHK;
            pkbfi_pkg::BS_CHK:
                if ({1'b0, r_pos} + (UW+1)'(pkbfi_pkg::HDR_BYTES) > {1'b0, r_used})
                    n_st = pkbfi_pkg::BS_INS_HDR0;
                else
                    n_st = pkbfi_pkg::BS_HDR0;
            pkbfi_pkg::BS_HDR0: n_st = pkbfi_pkg::BS_HDR1;
            pkbfi_pkg::BS_HDR1: n_st = pkbfi_pkg::BS_CMP;
            pkbfi_pkg::BS_CMP: if (r_pend) begin
                if (w_end > {2'b0, r_used})
                    n_st = pkbfi_pkg::BS_INS_HDR0;
                else if (r_elen != UW'(r_job.len))
                    n_st = pkbfi_pkg::BS_CHK;
                else if (r_vb != 2'd0) begin
                    if (w_mis) n_st = pkbfi_pkg::BS_CHK;
                    else if (w_klast) n_st = pkbfi_pkg::BS_VAL;
                end
            end
            pkbfi_pkg::BS_VAL: if (r_pend && r_vb == 2'd3)
                n_st = pkbfi_pkg::BS_DONE;
            pkbfi_pkg::BS_DONE: n_st = pkbfi_pkg::BS_IDLE;
            pkbfi_pkg::BS_INS_HDR0:
                n_st = w_full ? pkbfi_pkg::BS_IDLE : pkbfi_pkg::BS_INS_HDR1;
            pkbfi_pkg::BS_INS_HDR1: n_st = pkbfi_pkg::BS_INS_KEY;
            pkbfi_pkg::BS_INS_KEY: if (r_pend && w_klast)
                n_st = pkbfi_pkg::BS_INS_VAL;
            pkbfi_pkg::BS_INS_VAL: if (r_vb == 2'd3)
                n_st = pkbfi_pkg::BS_IDLE;
            default: n_st = pkbfi_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = '0;
        case (r_st)
            pkbfi_pkg::BS_INS_HDR0: begin
                w_we = !w_full; w_waddr = r_used[AW-1:0]; w_wdata = 8'(r_job.len);
            end
            pkbfi_pkg::BS_INS_HDR1: begin w_we = 1'b1; w_wdata = '0; end
            pkbfi_pkg::BS_INS_KEY: begin w_we = r_pend; w_wdata = i_rd_data; end
            pkbfi_pkg::BS_INS_VAL: begin w_we = 1'b1; w_wdata = r_job.value[8*r_vb +: 8]; end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr[AW-1:0]];
    end

    // Datapath. Memory reads are registered: r_pend marks that r_rdata
    // (or i_rd_data) holds the byte requested in the previous cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pkbfi_pkg::BS_IDLE;
            r_used <= '0;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_done <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                pkbfi_pkg::BS_IDLE: if (i_job_valid && o_job_ready) begin
                    r_job <= i_job;
                    r_pos <= '0;
                    r_idx <= '0;
                    r_pend <= 1'b0;
                    if (i_job.overflow) begin
                        r_ovalid <= 1'b1; r_done <= 1'b1;
                        r_ostat <= pkbfi_pkg::ST_TOO_LONG;
                        r_ooff <= '0; r_oval <= '0;
                    end
                end
                pkbfi_pkg::BS_CHK: r_idx <= r_pos;
                pkbfi_pkg::BS_HDR0: r_idx <= r_pos + 1'b1;
                pkbfi_pkg::BS_HDR1: begin
                    r_elen <= UW'(r_rdata);
                    r_pend <= 1'b0;
                end
                pkbfi_pkg::BS_CMP: begin
                    if (!r_pend) begin
                        r_elen <= r_elen | (UW'(r_rdata) << 8);
                        r_pend <= 1'b1;
                        r_kidx <= '0;
                        r_vb <= 2'd0;
                        r_idx <= r_pos + UW'(pkbfi_pkg::HDR_BYTES);
                    end else if (w_end > {2'b0, r_used}) begin
                        r_pend <= 1'b0;
                    end else if (r_elen != UW'(r_job.len)) begin
                        r_pos <= w_end[UW-1:0];
                        r_pend <= 1'b0;
                    end else if (r_vb == 2'd0) begin
                        // address issued at r_kidx, data arrives in the next cycle
                        r_vb <= 2'd1;
                    end else begin
                        r_vb <= 2'd0;
                        if (w_mis) begin
                            r_pos <= w_end[UW-1:0];
                            r_pend <= 1'b0;
                        end else if (w_klast) begin
                            r_idx <= r_pos + UW'(pkbfi_pkg::HDR_BYTES) + r_elen;
                            r_val <= '0;
                            r_pend <= 1'b0;
                        end else begin
                            r_kidx <= r_kidx + 1'b1;
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                pkbfi_pkg::BS_VAL: begin
                    if (r_pend) begin
                        r_val[8*r_vb +: 8] <= r_rdata;
                        r_vb <= r_vb + 1'b1;
                    end
                    r_pend <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                end
                pkbfi_pkg::BS_DONE: begin
                    r_ovalid <= 1'b1; r_done <= 1'b1;
                    r_ostat <= pkbfi_pkg::ST_FOUND;
                    r_ooff <= r_pos[11:0]; r_oval <= r_val;
                end
                pkbfi_pkg::BS_INS_HDR0: begin
                    if (w_full) begin
                        r_ovalid <= 1'b1; r_done <= 1'b1;
                        r_ostat <= pkbfi_pkg::ST_FULL;
                        r_ooff <= '0; r_oval <= '0;
                    end else begin
                        // low header byte goes out this cycle, high byte next
                        r_pos <= r_used;
                        r_idx <= r_used + 1'b1;
                    end
                end
                pkbfi_pkg::BS_INS_HDR1: begin
                    r_idx <= r_idx + 1'b1;
                    r_kidx <= '0;
                    r_pend <= 1'b0;
                end
                pkbfi_pkg::BS_INS_KEY: begin
                    if (!r_pend) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_pend <= 1'b0;
                        if (w_klast) r_vb <= 2'd0;
                        else r_kidx <= r_kidx + 1'b1;
                    end
                end
                pkbfi_pkg::BS_INS_VAL: begin
                    r_idx <= r_idx + 1'b1;
                    r_vb <= r_vb + 1'b1;
                    if (r_vb == 2'd3) begin
                        r_used <= w_need[UW-1:0];
                        r_ovalid <= 1'b1; r_done <= 1'b1;
                        r_ostat <= pkbfi_pkg::ST_INSERTED;
                        r_ooff <= r_pos[11:0]; r_oval <= r_job.value;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(pkbfi_pkg::BUCKET_BYTES)) else $error("used bytes beyond bucket");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> !r_ovalid) else $error("job taken with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid) else $error("result dropped");
`endif
endmodule

// ----- test/pkbfi_checker.sv -----
// Checker for the packed key bucket find-or-insert block: watches both channels,
// predicts each lookup result and compares it. Depends on pkbfi_pkg and pkbfi_if.
`timescale 1ns / 1ps
module pkbfi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pkbfi_in_if         in_ch,
    pkbfi_out_if        out_ch,
    output int          o_errors,
    output int          o_pending,
    output int          o_found,
    output int          o_inserted,
    output int          o_full,
    output int          o_too_long
);
    typedef struct {
        pkbfi_pkg::t_status status;
        logic [11:0]        offset;
        logic [31:0]        value;
    } t_lookup;

    t_lookup     lookup_q[$];
    int          ent_off[$];
    int          ent_len[$];
    logic [511:0] ent_key[$];
    logic [31:0] ent_val[$];
    logic [511:0] key_acc;
    int          key_len;
    bit          key_ovf;
    int          used;

    assign o_pending = lookup_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    // Run one completed key against the bucket image.
    function automatic t_lookup find_or_insert(input logic [31:0] nv);
        t_lookup r;
        r.status = pkbfi_pkg::ST_INSERTED;
        r.offset = '0;
        r.value  = '0;
        if (key_ovf) begin
            r.status = pkbfi_pkg::ST_TOO_LONG;
            return r;
        end
        for (int e = 0; e < ent_off.size(); e++) begin
            if (ent_len[e] == key_len && ent_key[e] == key_acc) begin
                r.status = pkbfi_pkg::ST_FOUND;
                r.offset = ent_off[e][11:0];
                r.value  = ent_val[e];
                return r;
            end
        end
        if (used + pkbfi_pkg::HDR_BYTES + key_len + pkbfi_pkg::VAL_BYTES
                > pkbfi_pkg::BUCKET_BYTES) begin
            r.status = pkbfi_pkg::ST_FULL;
            return r;
        end
        ent_off = {ent_off, used};
        ent_len = {ent_len, key_len};
        ent_key = {ent_key, key_acc};
        ent_val = {ent_val, nv};
        r.offset = used[11:0];
        r.value  = nv;
        used += pkbfi_pkg::HDR_BYTES + key_len + pkbfi_pkg::VAL_BYTES;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup res;
        if (!i_rst_n) begin
            key_acc = '0;
            key_len = 0;
            key_ovf = 0;
            used    = 0;
            o_errors = 0;
            o_found = 0;
            o_inserted = 0;
            o_full = 0;
            o_too_long = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (key_len < pkbfi_pkg::MAX_KEY_LEN) begin
                    key_acc[key_len*8 +: 8] = in_ch.key_byte;
                    key_len++;
                end else begin
                    key_ovf = 1;
                end
                if (in_ch.key_last) begin
                    res = find_or_insert(in_ch.new_value);
                    lookup_q = {lookup_q, res};
                    key_acc = '0;
                    key_len = 0;
                    key_ovf = 0;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (lookup_q.size() == 0) begin
                    report("unexpected word, status", out_ch.status, 0);
                end else begin
                    want = lookup_q.pop_front();
                    if (out_ch.status != want.status)
                        report("status", out_ch.status, want.status);
                    if (out_ch.entry_offset != want.offset)
                        report("entry_offset", out_ch.entry_offset, want.offset);
                    if (out_ch.stored_value != want.value)
                        report("stored_value", out_ch.stored_value, want.value);
                    case (want.status)
                        pkbfi_pkg::ST_FOUND:    o_found++;
                        pkbfi_pkg::ST_INSERTED: o_inserted++;
                        pkbfi_pkg::ST_FULL:     o_full++;
                        default:                o_too_long++;
                    endcase
                end
            end
        end
    end
endmodule

// ----- test/packed_key_bucket_find_or_insert_test.sv -----
// Testbench top: streams keys into the find-or-insert block under varying idle
// and stall patterns. Depends on pkbfi_pkg, pkbfi_if and pkbfi_checker.
`timescale 1ns / 1ps
module packed_key_bucket_find_or_insert_test;
    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, n_found, n_inserted, n_full, n_too_long;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;
    int   bytes_sent = 0;
    int   keys_sent = 0;
    logic [559:0] key_pool[$];
    int           len_pool[$];

    pkbfi_in_if  in_ch ();
    pkbfi_out_if out_ch ();

    packed_key_bucket_find_or_insert dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_ch),
        .m_out  (out_ch)
    );

    pkbfi_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_found   (n_found),
        .o_inserted(n_inserted),
        .o_full    (n_full),
        .o_too_long(n_too_long)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0;
        in_ch.key_byte = '0;
        in_ch.key_last = 0;
        in_ch.new_value = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Hold valid across back-to-back words; drop it only for idle cycles.
    task automatic put_byte(input logic [7:0] b, input logic last, input logic [31:0] nv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1;
        in_ch.key_byte  <= b;
        in_ch.key_last  <= last;
        in_ch.new_value <= nv;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic put_key(input logic [559:0] k, input int len, input logic [31:0] nv);
        for (int i = 0; i < len; i++)
            put_byte(k[i*8 +: 8], i == len - 1, (i == len - 1) ? nv : $urandom());
        keys_sent++;
        key_pool = {key_pool, k};
        len_pool = {len_pool, len};
    endtask

    function automatic logic [559:0] random_key(input int len);
        logic [559:0] k = '0;
        for (int i = 0; i < len; i++)
            k[i*8 +: 8] = 8'($urandom());
        return k;
    endfunction

    initial begin
        int len, pick, phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: byte and value extremes, hits, maximal and overlong keys.
        put_key(560'h00, 1, 32'h8000_0000);
        put_key(560'hFF, 1, 32'h7FFF_FFFF);
        put_key(560'h00, 1, 32'h0000_0001);
        put_key(560'hFF, 1, 32'hFFFF_FFFF);
        put_key({70{8'hFF}}, 64, 32'h0000_0000);
        put_key({70{8'hFF}}, 65, 32'h1234_5678);
        put_key({70{8'hFF}}, 64, 32'h5555_5555);
        put_key(560'h00FF, 2, 32'hAAAA_AAAA);

        // Random keys, with earlier keys reused for hits.
        while (bytes_sent < 750) begin
            phase = (keys_sent / 10) % 4;
            send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 29 : 0;
            recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 29 : 0;
            if ($urandom_range(99) < 35 && key_pool.size() > 0) begin
                pick = $urandom_range(key_pool.size() - 1);
                put_key(key_pool[pick], len_pool[pick], $urandom());
            end else begin
                pick = $urandom_range(99);
                if (pick < 40)      len = $urandom_range(1, 4);
                else if (pick < 65) len = $urandom_range(5, 20);
                else if (pick < 94) len = $urandom_range(40, 64);
                else                len = $urandom_range(65, 70);
                put_key(random_key(len), len, $urandom());
            end
        end
        in_ch.valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("ran %0d keys in %0d bytes: %0d found, %0d inserted, %0d full, %0d too long",
                 keys_sent, bytes_sent, n_found, n_inserted, n_full, n_too_long);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
